FILE: rtl/stepper_halfstep_sweep_return_top_macros.svh
// Assertion macros for the stepper half-step sweep block.
// Included by stepper_halfstep_sweep_return_top.sv; no other dependencies.
`ifndef STEPPER_HALFSTEP_SWEEP_RETURN_TOP_MACROS_SVH
`define STEPPER_HALFSTEP_SWEEP_RETURN_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define SHSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define SHSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/shss_pkg.sv
// Shared constants and helpers for the stepper half-step sweep block.
// No dependencies; imported by stepper_halfstep_sweep_return_top.
`default_nettype none

package shss_pkg;

   // Register map indexes
   localparam logic [1:0] REG_STEPS_PER_SWEEP  = 2'd0;
   localparam logic [1:0] REG_STEP_DELAY_TICKS = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd2;

   // Register reset values
   localparam logic [7:0]  STEPS_RESET    = 8'd9;
   localparam logic [15:0] DELAY_RESET    = 16'd5000;
   localparam logic [7:0]  DEBOUNCE_RESET = 8'd50;

   // Half-step coil pattern for a phase
   function automatic logic [3:0] half_step_pattern(input logic [2:0] phase);
      logic [3:0] pat;
      unique case (phase)
         3'd0: pat = 4'b0001;
         3'd1: pat = 4'b0011;
         3'd2: pat = 4'b0010;
         3'd3: pat = 4'b0110;
         3'd4: pat = 4'b0100;
         3'd5: pat = 4'b1100;
         3'd6: pat = 4'b1000;
         3'd7: pat = 4'b1001;
         default: pat = 4'b0000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stepper_halfstep_sweep_return_top.sv
// Latency: a result appears in the output register the cycle after its tick transfers.
// Throughput: one tick per cycle while the result side does not stall; the single
// next-state stage between the state registers and the result register sets this.
// The output register frees itself when taken, so a new tick transfers while a result waits
// only if the result side is not stalling.
// Reset clears sweep and debounce state and loads the register defaults (9, 5000, 50).
`default_nettype none

`include "stepper_halfstep_sweep_return_top_macros.svh"

module stepper_halfstep_sweep_return_top
   import shss_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // tick input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_button_pin,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_coils,
   output logic             rsp_busy_res,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_BACK = 2'd2
   } mode_type;

   // Configuration registers
   logic [7:0]  steps_per_sweep_ff;
   logic [15:0] step_delay_ticks_ff;
   logic [7:0]  debounce_ticks_ff;

   // Sweep and debounce state
   mode_type    mode_ff, mode_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  steps_done_ff, steps_done_in;
   logic [15:0] delay_left_ff, delay_left_in;
   logic [7:0]  debounce_left_ff, debounce_left_in;
   logic        debounce_active_ff, debounce_active_in;
   logic        last_pin_ff, last_pin_in;
   logic [3:0]  coil_drive_ff, coil_drive_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_coils_ff;
   logic        rsp_busy_ff;

   logic        req_xfer;
   logic [15:0] delay_reload;

   // Hold the tick while a result waits and the result side stalls
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign delay_reload = (step_delay_ticks_ff == 16'd0) ? 16'd0 : step_delay_ticks_ff - 16'd1;

   // Next state for one tick: sweep first, then debounce
   always_comb begin
      logic       do_back;
      logic [7:0] back_steps;
      logic [2:0] back_phase;

      mode_in            = mode_ff;
      phase_in           = phase_ff;
      steps_done_in      = steps_done_ff;
      delay_left_in      = delay_left_ff;
      debounce_left_in   = debounce_left_ff;
      debounce_active_in = debounce_active_ff;
      coil_drive_in      = coil_drive_ff;
      last_pin_in        = req_button_pin;
      do_back            = 1'b0;
      back_steps         = steps_done_ff;
      back_phase         = phase_ff - 3'd1;

      // Advance the sweep
      unique case (mode_ff)
         MODE_FWD: begin
            if (delay_left_ff != 16'd0) begin
               delay_left_in = delay_left_ff - 16'd1;
            end else if (steps_done_ff >= steps_per_sweep_ff) begin
               mode_in    = MODE_BACK;
               do_back    = 1'b1;
               back_steps = 8'd0;
            end else begin
               coil_drive_in = half_step_pattern(phase_ff);
               phase_in      = phase_ff + 3'd1;
               steps_done_in = steps_done_ff + 8'd1;
               delay_left_in = delay_reload;
            end
         end
         MODE_BACK: begin
            if (delay_left_ff != 16'd0) begin
               delay_left_in = delay_left_ff - 16'd1;
            end else begin
               do_back = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // Step backward, or finish the sweep
      if (do_back) begin
         if (back_steps >= steps_per_sweep_ff) begin
            mode_in       = MODE_IDLE;
            steps_done_in = 8'd0;
            delay_left_in = 16'd0;
         end else begin
            phase_in      = back_phase;
            coil_drive_in = half_step_pattern(back_phase);
            steps_done_in = back_steps + 8'd1;
            delay_left_in = delay_reload;
         end
      end

      // Start a debounce count on a falling edge
      if (last_pin_ff && !req_button_pin && !debounce_active_ff) begin
         debounce_active_in = 1'b1;
         debounce_left_in   = debounce_ticks_ff;
      end

      // Recheck the pin when the count expires
      if (debounce_active_in) begin
         if (debounce_left_in == 8'd0) begin
            debounce_active_in = 1'b0;
            if (!req_button_pin && mode_in == MODE_IDLE) begin
               mode_in       = MODE_FWD;
               steps_done_in = 8'd0;
               delay_left_in = 16'd0;
            end
         end else begin
            debounce_left_in = debounce_left_in - 8'd1;
         end
      end
   end

   // Drop the result once taken, load a new one on each tick transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_sweep_ff  <= STEPS_RESET;
         step_delay_ticks_ff <= DELAY_RESET;
         debounce_ticks_ff   <= DEBOUNCE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_STEPS_PER_SWEEP:  steps_per_sweep_ff  <= csr_wdata[7:0];
            REG_STEP_DELAY_TICKS: step_delay_ticks_ff <= csr_wdata;
            REG_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_IDLE;
         phase_ff           <= 3'd0;
         steps_done_ff      <= 8'd0;
         delay_left_ff      <= 16'd0;
         debounce_left_ff   <= 8'd0;
         debounce_active_ff <= 1'b0;
         last_pin_ff        <= 1'b1;
         coil_drive_ff      <= 4'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            mode_ff            <= mode_in;
            phase_ff           <= phase_in;
            steps_done_ff      <= steps_done_in;
            delay_left_ff      <= delay_left_in;
            debounce_left_ff   <= debounce_left_in;
            debounce_active_ff <= debounce_active_in;
            last_pin_ff        <= last_pin_in;
            coil_drive_ff      <= coil_drive_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_coils_ff <= coil_drive_in;
         rsp_busy_ff  <= (mode_in == MODE_FWD) || (mode_in == MODE_BACK);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coils    = rsp_coils_ff;
   assign rsp_busy_res = rsp_busy_ff;

   // Checks
   `SHSS_ASSERT_NEXT(a_xfer_gives_result, clock, reset, req_xfer, rsp_valid, "tick transfer gave no result")
   `SHSS_ASSERT_SAME(a_idle_counters_clear, clock, reset, mode_ff == MODE_IDLE, (steps_done_ff == 8'd0) && (delay_left_ff == 16'd0), "idle with sweep counters not clear")
   `SHSS_ASSERT_NEXT(a_phase_single_step, clock, reset, 1'b1, (phase_ff == $past(phase_ff)) || (phase_ff == $past(phase_ff) + 3'd1) || (phase_ff == $past(phase_ff) - 3'd1), "phase moved by more than one half-step")

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for the half-step stepper sweep block: button ticks go in, and every
// coil/busy result is checked against an in-bench predictor. Depends on shss_pkg
// and stepper_halfstep_sweep_return_top.

module tb;
   import shss_pkg::*;

   localparam logic [1:0]  REG_UNUSED     = 2'd3;
   localparam int unsigned CYCLE_LIMIT    = 2000000;
   localparam int          DRAIN_CYCLES   = 4;
   localparam int          RANDOM_TICKS   = 90;

   typedef enum logic [1:0] {
      SWEEP_IDLE   = 2'd0,
      SWEEP_FWD    = 2'd1,
      SWEEP_BACK   = 2'd2,
      SWEEP_UNUSED = 2'd3
   } sweep_mode_type;

   typedef struct packed {
      logic [3:0] coils;
      logic       busy;
   } coil_state_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_button_pin = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [3:0]  rsp_coils;
   logic        rsp_busy_res;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index      = REG_STEPS_PER_SWEEP;
   logic [15:0] csr_wdata      = '0;

   // Predictor copy of the registers and the sweep state
   logic [7:0]     cfg_steps      = STEPS_RESET;
   logic [15:0]    cfg_delay      = DELAY_RESET;
   logic [7:0]     cfg_debounce   = DEBOUNCE_RESET;
   logic [2:0]     cur_phase      = '0;
   sweep_mode_type cur_mode       = SWEEP_IDLE;
   logic [7:0]     steps_taken    = '0;
   logic [15:0]    delay_count    = '0;
   logic [7:0]     debounce_count = '0;
   logic           debounce_on    = 1'b0;
   logic           prev_pin       = 1'b1;
   logic [3:0]     coil_drive     = '0;

   coil_state_type coil_expect_q[$];
   int          error_count    = 0;
   int          ticks_sent     = 0;
   int unsigned cycle_count    = 0;
   int          send_idle_pct  = 17;
   int          recv_idle_pct  = 46;

   stepper_halfstep_sweep_return_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_button_pin (req_button_pin),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_coils      (rsp_coils),
      .rsp_busy_res   (rsp_busy_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coil_expect_q.size() == 0) begin
            $display("%0t: result with nothing expected: coils %h busy %b",
                     $time, rsp_coils, rsp_busy_res);
            error_count++;
         end else begin
            if (rsp_coils !== coil_expect_q[0].coils) begin
               $display("%0t: coils mismatch: expected %h, actual %h",
                        $time, coil_expect_q[0].coils, rsp_coils);
               error_count++;
            end
            if (rsp_busy_res !== coil_expect_q[0].busy) begin
               $display("%0t: busy mismatch: expected %b, actual %b",
                        $time, coil_expect_q[0].busy, rsp_busy_res);
               error_count++;
            end
            void'(coil_expect_q.pop_front());
         end
      end
   end

   function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
      case (ph)
         3'd0:    return 4'b0001;
         3'd1:    return 4'b0011;
         3'd2:    return 4'b0010;
         3'd3:    return 4'b0110;
         3'd4:    return 4'b0100;
         3'd5:    return 4'b1100;
         3'd6:    return 4'b1000;
         default: return 4'b1001;
      endcase
   endfunction

   // A zero delay behaves as one tick
   task automatic reload_delay();
      delay_count = (cfg_delay == 16'd0) ? 16'd0 : cfg_delay - 16'd1;
   endtask

   // Step back one phase, or end the sweep once all steps are done
   task automatic step_back();
      if (steps_taken >= cfg_steps) begin
         cur_mode    = SWEEP_IDLE;
         steps_taken = '0;
         delay_count = '0;
      end else begin
         cur_phase   = cur_phase - 3'd1;
         coil_drive  = coil_pattern(cur_phase);
         steps_taken = steps_taken + 8'd1;
         reload_delay();
      end
   endtask

   // Advance the predictor by one tick and queue the expected result
   task automatic predict_tick(input logic pin);
      coil_state_type exp_res;
      // sweep first
      if (cur_mode != SWEEP_FWD && cur_mode != SWEEP_BACK) begin
         cur_mode = SWEEP_IDLE;
      end else if (delay_count != 16'd0) begin
         delay_count = delay_count - 16'd1;
      end else if (cur_mode == SWEEP_BACK) begin
         step_back();
      end else if (steps_taken >= cfg_steps) begin
         cur_mode    = SWEEP_BACK;
         steps_taken = '0;
         step_back();
      end else begin
         coil_drive  = coil_pattern(cur_phase);
         cur_phase   = cur_phase + 3'd1;
         steps_taken = steps_taken + 8'd1;
         reload_delay();
      end
      // then the debounce; a new edge during a running count is ignored
      if (prev_pin && !pin && !debounce_on) begin
         debounce_on    = 1'b1;
         debounce_count = cfg_debounce;
      end
      if (debounce_on) begin
         if (debounce_count == 8'd0) begin
            debounce_on = 1'b0;
            if (!pin && cur_mode == SWEEP_IDLE) begin
               cur_mode    = SWEEP_FWD;
               steps_taken = '0;
               delay_count = '0;
            end
         end else begin
            debounce_count = debounce_count - 8'd1;
         end
      end
      prev_pin      = pin;
      exp_res.coils = coil_drive;
      exp_res.busy  = (cur_mode == SWEEP_FWD || cur_mode == SWEEP_BACK);
      coil_expect_q.push_back(exp_res);
   endtask

   // Send one tick; valid stays high after the transfer until the next call decides
   task automatic send_tick(input logic pin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_button_pin <= pin;
      do @(posedge clock); while (req_stall);
      predict_tick(pin);
      ticks_sent++;
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (coil_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_STEPS_PER_SWEEP:  cfg_steps    = value[7:0];
         REG_STEP_DELAY_TICKS: cfg_delay    = value;
         REG_DEBOUNCE_TICKS:   cfg_debounce = value[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Release if needed, then hold the button down until the debounce resolves
   task automatic start_sweep();
      if (!prev_pin) send_tick(1'b1);
      do send_tick(1'b0); while (cur_mode == SWEEP_IDLE && debounce_on);
   endtask

   task automatic finish_sweep();
      while (cur_mode != SWEEP_IDLE) send_tick(1'b1);
   endtask

   // Random small register settings; junk in the unused upper bits
   task automatic retune(input bit every);
      logic [15:0] wd;
      if (every || $urandom_range(1)) begin
         wd      = 16'($urandom);
         wd[7:0] = 8'($urandom_range(6));
         write_csr(REG_STEPS_PER_SWEEP, wd);
      end
      if (every || $urandom_range(1)) begin
         write_csr(REG_STEP_DELAY_TICKS, 16'($urandom_range(4)));
      end
      if (every || $urandom_range(1)) begin
         wd      = 16'($urandom);
         wd[7:0] = 8'($urandom_range(5));
         write_csr(REG_DEBOUNCE_TICKS, wd);
      end
      if (!every && $urandom_range(7) == 0) begin
         write_csr(REG_UNUSED, 16'($urandom));
      end
   endtask

   task automatic test_reset_defaults();
      // short step delay keeps the default nine steps and debounce of 50 quick
      write_csr(REG_STEP_DELAY_TICKS, 16'd3);
      start_sweep();
      finish_sweep();
      // sweep again up to the second forward step
      start_sweep();
      while (steps_taken < 8'd2) send_tick(1'b1);
      // cut it short: zero steps, upper byte must be dropped
      write_csr(REG_STEPS_PER_SWEEP, 16'hA500);
      finish_sweep();
   endtask

   task automatic test_debounce();
      write_csr(REG_STEPS_PER_SWEEP, 16'd2);
      write_csr(REG_STEP_DELAY_TICKS, 16'd2);
      write_csr(REG_DEBOUNCE_TICKS, 16'd4);
      // released before the recheck: no sweep
      send_tick(1'b0);
      send_tick(1'b0);
      repeat (6) send_tick(1'b1);
      // bounce inside the count: a further falling edge does not restart it
      send_tick(1'b0);
      send_tick(1'b1);
      start_sweep();
      // full press while sweeping: ignored
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      finish_sweep();
      // zero debounce rechecks in the edge tick
      write_csr(REG_DEBOUNCE_TICKS, 16'hFF00);
      start_sweep();
      finish_sweep();
      write_csr(REG_DEBOUNCE_TICKS, 16'h00FF);
      start_sweep();
      finish_sweep();
   endtask

   task automatic test_step_counts();
      write_csr(REG_DEBOUNCE_TICKS, 16'd1);
      write_csr(REG_STEP_DELAY_TICKS, 16'd1);
      // longest sweep wraps the phase both ways
      write_csr(REG_STEPS_PER_SWEEP, 16'hFFFF);
      start_sweep();
      finish_sweep();
      // zero steps: ends on the first action, coils hold
      write_csr(REG_STEPS_PER_SWEEP, 16'h0000);
      start_sweep();
      finish_sweep();
      // zero delay acts as one tick
      write_csr(REG_STEPS_PER_SWEEP, 16'd3);
      write_csr(REG_STEP_DELAY_TICKS, 16'd0);
      start_sweep();
      finish_sweep();
   endtask

   task automatic test_step_delay_extremes();
      write_csr(REG_UNUSED, 16'hFFFF);
      write_csr(REG_STEPS_PER_SWEEP, 16'd1);
      write_csr(REG_STEP_DELAY_TICKS, 16'd1);
      write_csr(REG_DEBOUNCE_TICKS, 16'd0);
      start_sweep();
      send_tick(1'b1);
      // stretch the gap after the forward step past the low byte of the delay
      write_csr(REG_STEP_DELAY_TICKS, 16'h0100);
      finish_sweep();
   endtask

   task automatic test_random_sweeps(input int s_pct, input int r_pct);
      int stop_at;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      retune(1'b1);
      stop_at = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(3) == 0) retune(1'b0);
         case ($urandom_range(9))
            0: begin
               // pin noise
               repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
            end
            1: begin
               // short press, likely released before the recheck
               send_tick(1'b1);
               repeat ($urandom_range(1, 3)) send_tick(1'b0);
               repeat ($urandom_range(1, 6)) send_tick(1'b1);
            end
            default: begin
               // clean press, sometimes after bounce
               if ($urandom_range(2) == 0) begin
                  repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(1)));
               end
               start_sweep();
               repeat ($urandom_range(3)) send_tick(1'b0);
               // sometimes leave mid-sweep so the next press lands in it
               if ($urandom_range(3) == 0) begin
                  repeat ($urandom_range(1, 12)) send_tick(1'b1);
               end else begin
                  finish_sweep();
               end
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_debounce();
      test_step_counts();
      test_step_delay_extremes();
      test_random_sweeps(17, 46);
      test_random_sweeps(46, 17);
      test_random_sweeps(0, 0);
      drain_results();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/shss_pkg.sv
rtl/stepper_halfstep_sweep_return_top.sv
verif/tb.sv
